### hw/rtl/irc_line_tokenizer_top_macros.svh
// ----------------------------------------------------------------------------
// irc_line_tokenizer_top_macros: assertion macros
// Concurrent checks on clk; empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef IRC_LINE_TOKENIZER_TOP_MACROS_SVH
`define IRC_LINE_TOKENIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check a property outside of reset.
`define IRCLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property at every edge, reset included.
`define IRCLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IRCLT_ASSERT(lbl, prop, msg)
`define IRCLT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hw/rtl/irclt_pkg.sv
// ----------------------------------------------------------------------------
// irclt_pkg
// Types and codes shared by the chat line tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package irclt_pkg;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_BANG  = 8'h21;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  typedef enum logic [2:0] {
    MODE_LEAD    = 3'd0,
    MODE_SRC     = 3'd1,
    MODE_SRCX    = 3'd2,
    MODE_PREVERB = 3'd3,
    MODE_VERB    = 3'd4,
    MODE_GAP     = 3'd5,
    MODE_MID     = 3'd6,
    MODE_TRAIL   = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    KIND_SEP   = 3'd0,
    KIND_SRC   = 3'd1,
    KIND_SRCX  = 3'd2,
    KIND_VERB  = 3'd3,
    KIND_MID   = 3'd4,
    KIND_TRAIL = 3'd5,
    KIND_DROP  = 3'd6
  } kind_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_of_line;
  } item_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] field_kind;
    logic       field_first;
    logic [4:0] param_index;
    logic [5:0] param_count;
    logic       too_many;
    logic       line_done;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/irc_line_tokenizer_top.sv
// ----------------------------------------------------------------------------
// irc_line_tokenizer_top
// Labels each byte of a chat protocol message line with the field it opens
// or belongs to: source, source extra, verb, middle or trailing parameter.
// ----------------------------------------------------------------------------
// Unless the output stalls, one byte is taken per clock and its label enters
// the result register, so the block sustains one byte per cycle. The figure is
// set by the parse mode and parameter count registers, which update in the
// same cycle a byte is accepted. A new byte is accepted whenever the result
// register is empty or being taken. Parse state returns to its reset value
// after the byte flagged as last of line. Parameters beyond PARAM_LIMIT
// (1 to 32) are labeled dropped and flag too_many for the rest of the line.
`timescale 1ns / 1ps
`default_nettype none

`include "irc_line_tokenizer_top_macros.svh"

module irc_line_tokenizer_top
  import irclt_pkg::*;
#(
  parameter int PARAM_LIMIT = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  localparam logic [5:0] LIMIT = 6'(PARAM_LIMIT);

  mode_t      mode, mode_next;
  logic [5:0] params_seen, seen_next;
  logic       overflowed, ovf_next;
  logic       halted, halt_next;

  kind_t      kind;
  logic       first;
  logic [4:0] pidx;
  logic       ws;
  logic       in_param;
  logic       trail;
  logic       accept;

  // Result register may take a new transaction when empty or being drained.
  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  always_comb begin
    ws = (item.char_byte == CHAR_SPACE) ||
         ((item.char_byte >= CHAR_TAB) && (item.char_byte <= CHAR_CR));
    mode_next = mode;
    seen_next = params_seen;
    ovf_next  = overflowed;
    halt_next = halted;
    kind      = KIND_SEP;
    first     = 1'b0;
    pidx      = '0;
    in_param  = 1'b0;
    trail     = 1'b0;
    if (halted || (item.char_byte == CHAR_NUL)) begin
      halt_next = 1'b1;
    end else begin
      case (mode)
        MODE_LEAD: begin
          if (!ws) begin
            first = 1'b1;
            if (item.char_byte == CHAR_COLON) begin
              kind      = KIND_SRC;
              mode_next = MODE_SRC;
            end else begin
              kind      = KIND_VERB;
              mode_next = MODE_VERB;
            end
          end
        end
        MODE_SRC: begin
          if (ws) begin
            mode_next = MODE_PREVERB;
          end else if (item.char_byte == CHAR_BANG) begin
            kind      = KIND_SRCX;
            first     = 1'b1;
            mode_next = MODE_SRCX;
          end else begin
            kind = KIND_SRC;
          end
        end
        MODE_SRCX: begin
          if (ws) mode_next = MODE_PREVERB;
          else kind = KIND_SRCX;
        end
        MODE_PREVERB: begin
          if (!ws) begin
            kind      = KIND_VERB;
            first     = 1'b1;
            mode_next = MODE_VERB;
          end
        end
        MODE_VERB: begin
          if (ws) mode_next = MODE_GAP;
          else kind = KIND_VERB;
        end
        MODE_GAP: begin
          if (!ws) begin
            // Count the new parameter unless the limit is reached.
            if (params_seen >= LIMIT) ovf_next = 1'b1;
            else seen_next = params_seen + 6'd1;
            first    = 1'b1;
            in_param = 1'b1;
            if (item.char_byte == CHAR_COLON) begin
              mode_next = MODE_TRAIL;
              trail     = 1'b1;
            end else begin
              mode_next = MODE_MID;
            end
          end
        end
        MODE_MID: begin
          if (ws) mode_next = MODE_GAP;
          else in_param = 1'b1;
        end
        MODE_TRAIL: begin
          in_param = 1'b1;
          trail    = 1'b1;
        end
        default: begin
          mode_next = MODE_LEAD;
        end
      endcase
      if (in_param) begin
        if (ovf_next || (seen_next == 6'd0)) begin
          kind = KIND_DROP;
        end else begin
          kind = trail ? KIND_TRAIL : KIND_MID;
          pidx = 5'(seen_next - 6'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_LEAD;
      params_seen <= '0;
      overflowed  <= 1'b0;
      halted      <= 1'b0;
    end else if (accept) begin
      if (item.last_of_line) begin
        mode        <= MODE_LEAD;
        params_seen <= '0;
        overflowed  <= 1'b0;
        halted      <= 1'b0;
      end else begin
        mode        <= mode_next;
        params_seen <= seen_next;
        overflowed  <= ovf_next;
        halted      <= halt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.byte_out    <= item.char_byte;
      result.field_kind  <= kind;
      result.field_first <= first;
      result.param_index <= pidx;
      result.param_count <= seen_next;
      result.too_many    <= ovf_next;
      result.line_done   <= item.last_of_line;
    end
  end

  `IRCLT_ASSERT(a_line_end_clears, accept && item.last_of_line |=> (mode == MODE_LEAD) && (params_seen == 6'd0) && !overflowed && !halted, "parse state not cleared after last byte")
  `IRCLT_ASSERT(a_drop_flags, result_valid && (result.field_kind == KIND_DROP) |-> result.too_many || (result.param_count == 6'd0), "dropped byte without overflow")
  `IRCLT_ASSERT(a_count_limit, result_valid |-> result.param_count <= LIMIT, "parameter count above limit")
  `IRCLT_ASSERT(a_index_only_params, result_valid && (result.field_kind != KIND_MID) && (result.field_kind != KIND_TRAIL) |-> result.param_index == 5'd0, "parameter index on a non-parameter byte")
  `IRCLT_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid after reset")

endmodule

`default_nettype wire

### sim/irc_line_tokenizer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irc_line_tokenizer_top_test
// Feeds chat message lines byte by byte through the tokenizer and checks
// every label against an in-bench parse of the same bytes. Both sides idle
// at random, with one long output hold and a drain before each line marked to pause.
// ----------------------------------------------------------------------------

module irc_line_tokenizer_top_test;
  import irclt_pkg::*;

  localparam int PARAM_LIMIT = 32;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD_AT = 400;
  localparam int LONG_HOLD_CYCLES = 300;

  typedef logic [7:0] line_t[$];

  typedef struct {
    item_t data;
    int    gap;
    bit    pause;
  } send_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  send_t   pending[$];
  result_t expected_labels[$];
  int      outstanding = 0;
  int      mismatches = 0;
  int      labels_checked = 0;
  int      cycle_count = 0;

  // Parse state of the line being labeled
  mode_t       line_mode = MODE_LEAD;
  logic [5:0]  params_counted = '0;
  logic        over_limit = 1'b0;
  logic        nul_seen = 1'b0;

  irc_line_tokenizer_top #(
    .PARAM_LIMIT(PARAM_LIMIT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic bit is_space(logic [7:0] b);
    return b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR);
  endfunction

  function automatic result_t label_byte(item_t it);
    result_t    r;
    logic [7:0] b;
    logic [4:0] pidx;
    logic       ws;
    logic       first;
    logic       in_param;
    kind_t      kind;
    kind_t      pkind;
    b = it.char_byte;
    ws = is_space(b);
    kind = KIND_SEP;
    pkind = KIND_MID;
    first = 1'b0;
    in_param = 1'b0;
    pidx = '0;
    if (nul_seen || b == CHAR_NUL) begin
      nul_seen = 1'b1;
    end else begin
      case (line_mode)
        MODE_LEAD: begin
          if (!ws) begin
            first = 1'b1;
            if (b == CHAR_COLON) begin
              kind = KIND_SRC;
              line_mode = MODE_SRC;
            end else begin
              kind = KIND_VERB;
              line_mode = MODE_VERB;
            end
          end
        end
        MODE_SRC: begin
          if (ws) begin
            line_mode = MODE_PREVERB;
          end else if (b == CHAR_BANG) begin
            kind = KIND_SRCX;
            first = 1'b1;
            line_mode = MODE_SRCX;
          end else begin
            kind = KIND_SRC;
          end
        end
        MODE_SRCX: begin
          if (ws) line_mode = MODE_PREVERB;
          else kind = KIND_SRCX;
        end
        MODE_PREVERB: begin
          if (!ws) begin
            kind = KIND_VERB;
            first = 1'b1;
            line_mode = MODE_VERB;
          end
        end
        MODE_VERB: begin
          if (ws) line_mode = MODE_GAP;
          else kind = KIND_VERB;
        end
        MODE_GAP: begin
          if (!ws) begin
            // A parameter past the limit is not counted and flags the line
            if (params_counted >= PARAM_LIMIT) over_limit = 1'b1;
            else params_counted = params_counted + 6'd1;
            first = 1'b1;
            in_param = 1'b1;
            if (b == CHAR_COLON) begin
              line_mode = MODE_TRAIL;
              pkind = KIND_TRAIL;
            end else begin
              line_mode = MODE_MID;
            end
          end
        end
        MODE_MID: begin
          if (ws) line_mode = MODE_GAP;
          else in_param = 1'b1;
        end
        default: begin
          in_param = 1'b1;
          pkind = KIND_TRAIL;
        end
      endcase
      if (in_param) begin
        if (over_limit || params_counted == 0) begin
          kind = KIND_DROP;
        end else begin
          kind = pkind;
          pidx = params_counted[4:0] - 5'd1;
        end
      end
    end
    r.byte_out = b;
    r.field_kind = kind;
    r.field_first = first;
    r.param_index = pidx;
    r.param_count = params_counted;
    r.too_many = over_limit;
    r.line_done = it.last_of_line;
    if (it.last_of_line) begin
      line_mode = MODE_LEAD;
      params_counted = '0;
      over_limit = 1'b0;
      nul_seen = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [7:0] space_byte();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? CHAR_SPACE : 8'(r);
  endfunction

  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: b = CHAR_COLON;
      1: b = CHAR_BANG;
      default: begin
        b = 8'($urandom_range(1, 255));
        while (is_space(b)) b = 8'($urandom_range(1, 255));
      end
    endcase
    return b;
  endfunction

  task automatic queue_line(line_t text, bit pause);
    send_t s;
    bit    calm;
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < text.size(); i++) begin
      s.data.char_byte = text[i];
      s.data.last_of_line = (i == text.size() - 1);
      s.gap = calm ? 0 : $urandom_range(0, 14);
      s.pause = pause && (i == 0);
      pending.push_back(s);
    end
  endtask

  task automatic queue_random_line(bit pause);
    line_t text;
    int    shape;
    int    n_params;
    int    keep;
    shape = $urandom_range(0, 19);
    if (shape < 3) begin
      // noise: arbitrary bytes
      repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) text.push_back(space_byte());
      if ($urandom_range(0, 1)) begin
        text.push_back(CHAR_COLON);
        repeat ($urandom_range(0, 4)) text.push_back(word_byte());
        if ($urandom_range(0, 2) == 0) begin
          text.push_back(CHAR_BANG);
          repeat ($urandom_range(0, 4)) text.push_back(word_byte());
        end
        repeat ($urandom_range(1, 2)) text.push_back(space_byte());
      end
      repeat ($urandom_range(1, 6)) text.push_back(word_byte());
      n_params = (shape < 5) ? $urandom_range(30, 36) : $urandom_range(0, 4);
      for (int p = 0; p < n_params; p++) begin
        repeat ($urandom_range(1, 2)) text.push_back(space_byte());
        if (p == n_params - 1 && $urandom_range(0, 1)) begin
          text.push_back(CHAR_COLON);
          repeat ($urandom_range(0, 6))
            text.push_back($urandom_range(0, 1) ? space_byte() : word_byte());
        end else begin
          repeat ($urandom_range(1, n_params > 8 ? 2 : 5)) text.push_back(word_byte());
        end
      end
      if ($urandom_range(0, 4) == 0) text.push_back(space_byte());
      // broken lines: a stray zero byte, or a line cut short
      if (shape == 5) text[$urandom_range(0, text.size() - 1)] = CHAR_NUL;
      if (shape == 6) begin
        keep = $urandom_range(1, text.size());
        while (text.size() > keep) void'(text.pop_back());
      end
    end
    queue_line(text, pause);
  endtask

  // Sender: offer queued bytes, each after its own idle gap
  int gap_left = 0;
  bit gap_loaded = 1'b0;

  always @(posedge clk) begin
    send_t next;
    bit    offer;
    if (rst) begin
      item_valid <= 1'b0;
      gap_loaded = 1'b0;
    end else begin
      offer = item_valid && item_stall;
      if (!offer && pending.size() != 0) begin
        if (!gap_loaded) begin
          gap_left = pending[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!pending[0].pause || (!item_valid && outstanding == 0)) begin
          next = pending.pop_front();
          item <= next.data;
          offer = 1'b1;
          gap_loaded = 1'b0;
        end
      end
      item_valid <= offer;
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("ERROR t=%0t %s expected %0h got %0h", $realtime, name, want, got);
    end
  endtask

  // Receiver: check each label, predict each accepted byte, stall at random
  int stall_left = 0;
  int hold_left = 0;
  bit rx_calm = 1'b0;

  always @(posedge clk) begin
    result_t want;
    bit      stall;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_labels.size() == 0) begin
          mismatches++;
          $display("ERROR t=%0t unexpected transaction, expected none got %0h",
                   $realtime, result);
        end else begin
          want = expected_labels.pop_front();
          check_field("byte_out", want.byte_out, result.byte_out);
          check_field("field_kind", 8'(want.field_kind), 8'(result.field_kind));
          check_field("field_first", 8'(want.field_first), 8'(result.field_first));
          check_field("param_index", 8'(want.param_index), 8'(result.param_index));
          check_field("param_count", 8'(want.param_count), 8'(result.param_count));
          check_field("too_many", 8'(want.too_many), 8'(result.too_many));
          check_field("line_done", 8'(want.line_done), 8'(result.line_done));
        end
        labels_checked++;
        if (labels_checked % 97 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        stall_left = rx_calm ? 0 : $urandom_range(0, 14);
        // hold the output long enough for the block to back up its input
        if (labels_checked == LONG_HOLD_AT) hold_left = LONG_HOLD_CYCLES;
      end
      if (item_valid && !item_stall) expected_labels.push_back(label_byte(item));
      outstanding <= expected_labels.size();
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall = 1'b1;
      end else begin
        stall = 1'b0;
      end
      result_stall <= stall;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int total;
    // empty source and extra, verb, empty trailing parameter
    queue_line('{CHAR_COLON, CHAR_BANG, CHAR_SPACE, "V", CHAR_SPACE, CHAR_COLON}, 1'b0);
    // leading tab, colon inside the verb, middle, trailing with colon, top byte
    queue_line('{CHAR_TAB, "X", CHAR_COLON, CHAR_SPACE, "m", CHAR_SPACE,
                 CHAR_COLON, CHAR_COLON, 8'hFF}, 1'b0);
    // source with extra, zero byte ends the text
    queue_line('{CHAR_COLON, "n", CHAR_BANG, "u", CHAR_CR, "P", CHAR_NUL, "z"}, 1'b0);
    // whitespace-only line
    queue_line('{CHAR_SPACE}, 1'b0);
    total = pending.size() + RANDOM_ITEMS;
    // wait for the directed lines to drain before the random part
    queue_random_line(1'b1);
    while (pending.size() < total) queue_random_line($urandom_range(0, 39) == 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending.size() != 0 || item_valid || outstanding != 0);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && expected_labels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
